[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/adl_pkg.sv]
// ----------------------------------------------------------------------------
// Adler-32 package
// Constants, types and helper functions shared by the checksum datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package adl_pkg;

   localparam int LANES_MAX     = 16;
   localparam int LANES_DEFAULT = 16;

   localparam logic [15:0] ADLER_MOD = 16'd65521;

   // Field widths of the channels.
   localparam int DATA_W  = 64;
   localparam int CNT_W   = 5;
   localparam int START_W = 32;
   localparam int SUM_W   = 16;

   // Widths of the lane products and merged totals, sized for the widest
   // configuration so that every lane count fits.
   localparam int PROD_W  = 12;   // 16 * 255
   localparam int TOTAL_W = 12;   // 16 * 255
   localparam int WSUM_W  = 16;   // 255 * 136
   localparam int ACC_W   = 21;   // 65520 + 16 * 65520 + 34680

   // 2^16 modulo 65521, used to fold the upper bits of a wide sum.
   localparam logic [4:0] FOLD_K = 5'd15;

   typedef struct packed {
      logic [7:0]        byte_val;
      logic [PROD_W-1:0] product;
   } lane_out_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [TOTAL_W-1:0] byte_total;
      logic [WSUM_W-1:0]  weighted;
      logic [SUM_W-1:0]   start_a;
      logic [SUM_W-1:0]   start_b;
      logic               first;
      logic               last;
   } stage_type;

   // Reduces a value below twice the modulus into the range 0..65520.
   function automatic logic [SUM_W-1:0] mod_reduce(input logic [SUM_W:0] value);
      logic [SUM_W:0] diff;
      diff = value - {1'b0, ADLER_MOD};
      if (value >= {1'b0, ADLER_MOD}) begin
         mod_reduce = diff[SUM_W-1:0];
      end else begin
         mod_reduce = value[SUM_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[sv/adl_if.sv]
// ----------------------------------------------------------------------------
// Adler-32 channel interfaces
// Valid/ready channels for the request items and the checksum results.
// ----------------------------------------------------------------------------
`default_nettype none

interface adl_req_if;
   import adl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DATA_W-1:0]    data_low;
   logic [DATA_W-1:0]    data_high;
   logic [CNT_W-1:0]     byte_count;
   logic                 first;
   logic                 last;
   logic [START_W-1:0]   start_value;

   modport source (
      output valid, data_low, data_high, byte_count, first, last, start_value,
      input  ready
   );

   modport sink (
      input  valid, data_low, data_high, byte_count, first, last, start_value,
      output ready
   );
endinterface

interface adl_rsp_if;
   import adl_pkg::*;

   logic               valid;
   logic               ready;
   logic [START_W-1:0] checksum;

   modport source (
      output valid, checksum,
      input  ready
   );

   modport sink (
      input  valid, checksum,
      output ready
   );
endinterface

`default_nettype wire

[sv/adl_lane.sv]
// ----------------------------------------------------------------------------
// Adler-32 byte lane
// Masks one stream byte by the item's byte count and weights it by position.
// ----------------------------------------------------------------------------
`default_nettype none

module adl_lane #(
   parameter int INDEX = 0
) (
   input  wire logic [7:0]               byte_in,
   input  wire logic [adl_pkg::CNT_W-1:0] count,
   output adl_pkg::lane_out_type         lane_out
);
   import adl_pkg::*;

   logic                   active;
   logic [CNT_W-1:0]       weight;
   logic [CNT_W+7:0]       prod_full;

   // A byte counts only when it lies inside the item; its weight is the
   // number of bytes from it to the end of the item, itself included.
   always_comb begin
      active    = CNT_W'(INDEX) < count;
      weight    = count - CNT_W'(INDEX);
      prod_full = {8'b0, weight} * {{CNT_W{1'b0}}, byte_in};
      if (active) begin
         lane_out.byte_val = byte_in;
         lane_out.product  = PROD_W'(prod_full);
      end else begin
         lane_out.byte_val = 8'd0;
         lane_out.product  = '0;
      end
   end

endmodule

`default_nettype wire

[sv/adl_merge.sv]
// ----------------------------------------------------------------------------
// Adler-32 lane merge
// Adds the lane results into the item's byte total and weighted total.
// ----------------------------------------------------------------------------
`default_nettype none

module adl_merge #(
   parameter int LANES = adl_pkg::LANES_DEFAULT
) (
   input  wire adl_pkg::lane_out_type         lane_res [LANES],
   output logic [adl_pkg::TOTAL_W-1:0]        byte_total,
   output logic [adl_pkg::WSUM_W-1:0]         weighted
);
   import adl_pkg::*;

   always_comb begin
      byte_total = '0;
      weighted   = '0;
      for (int i = 0; i < LANES; i++) begin
         byte_total = byte_total + TOTAL_W'(lane_res[i].byte_val);
         weighted   = weighted + WSUM_W'(lane_res[i].product);
      end
   end

endmodule

`default_nettype wire

[sv/adl_accum.sv]
// ----------------------------------------------------------------------------
// Adler-32 accumulator
// Holds the two running sums and updates them modulo 65521 once per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adl_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          commit,
   input  wire adl_pkg::stage_type            stage,
   output logic [adl_pkg::START_W-1:0]        next_checksum
);
   import adl_pkg::*;

   logic [SUM_W-1:0] sum_a_ff, sum_a_in;
   logic [SUM_W-1:0] sum_b_ff, sum_b_in;

   logic [SUM_W-1:0]       base_a, base_b;
   logic [SUM_W:0]         a_raw;
   logic [ACC_W-1:0]       b_raw;
   logic [ACC_W-SUM_W-1:0] b_hi;
   logic [SUM_W:0]         b_fold;

   // The sum of the second half is reduced by folding: 2^16 is 15 modulo
   // 65521, so the upper bits return multiplied by 15, which leaves a value
   // below twice the modulus for the final compare and subtract.
   always_comb begin
      base_a   = stage.first ? stage.start_a : sum_a_ff;
      base_b   = stage.first ? stage.start_b : sum_b_ff;
      a_raw    = {1'b0, base_a} + (SUM_W+1)'(stage.byte_total);
      b_raw    = ACC_W'(base_b) + ACC_W'(stage.count) * ACC_W'(base_a)
                 + ACC_W'(stage.weighted);
      b_hi     = b_raw[ACC_W-1:SUM_W];
      b_fold   = (SUM_W+1)'(b_hi) * (SUM_W+1)'(FOLD_K) + {1'b0, b_raw[SUM_W-1:0]};
      sum_a_in = mod_reduce(a_raw);
      sum_b_in = mod_reduce(b_fold);
      next_checksum = {sum_b_in, sum_a_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= 16'd1;
         sum_b_ff <= 16'd0;
      end else if (commit) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   `ASSERT_CLK(a_sums_reduced, clock, reset,
      (sum_a_ff < ADLER_MOD) && (sum_b_ff < ADLER_MOD),
      "running sums left the modulus range")
   `ASSERT_CLK(a_empty_first_loads, clock, reset,
      (commit && stage.first && stage.count == '0) |=>
      (sum_a_ff == $past(stage.start_a) && sum_b_ff == $past(stage.start_b)),
      "empty first item did not load the start value")
   `ASSERT_ALWAYS(a_reset_value, clock,
      $past(reset) |-> (sum_a_ff == 16'd1 && sum_b_ff == 16'd0),
      "sums not at their reset value")

endmodule

`default_nettype wire

[sv/adler32_16byte_lanes_unit.sv]
// ----------------------------------------------------------------------------
// Adler-32 checksum unit, sixteen byte lanes
// Streams up to LANES bytes per item into a running Adler-32 checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per handshake: up to LANES stream bytes
//   in data_low and data_high (earliest byte in the lowest bits), the number
//   of valid leading bytes, a first flag that reloads the sums from
//   start_value, and a last flag that asks for the checksum.
//   The rsp channel carries one checksum item for each item flagged last.
//   An accepted item is registered in stage one; when it advances, a last
//   item's checksum enters the output register, which drives rsp.valid.
//   Throughput: one item every cycle while req.ready is high, as the sum
//   update of one item is combinational ahead of the accumulator registers.
//   Reset (synchronous, active high) sets the sums to 1 and 0 and empties
//   the pipeline; a stream may then start with or without a first item.
//   When the receiver stalls, the checksum waits in the output register.
//   Items without the last flag still flow through; the unit only holds
//   req.ready low once a further last item would need that full register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adler32_16byte_lanes_unit #(
   parameter int LANES = adl_pkg::LANES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   adl_req_if.sink    req,
   adl_rsp_if.source  rsp
);
   import adl_pkg::*;

   // Byte count clipped to the number of lanes; bytes past it are ignored.
   logic [CNT_W-1:0] count_sat;

   lane_out_type       lane_res [LANES];
   logic [TOTAL_W-1:0] byte_total;
   logic [WSUM_W-1:0]  weighted;

   // Stage one register holds the merged lane totals of one item.
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;

   // Output register holds a checksum until the receiver takes it.
   logic               out_valid_ff, out_valid_in;
   logic [START_W-1:0] out_data_ff, out_data_in;

   logic               accept;
   logic               advance;
   logic [START_W-1:0] next_checksum;

   assign count_sat = (req.byte_count > CNT_W'(LANES)) ? CNT_W'(LANES) : req.byte_count;

   // One lane per byte position, each weighting its own byte.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [7:0] lane_byte;
      if (i < 8) begin : g_low
         assign lane_byte = req.data_low[i*8 +: 8];
      end else begin : g_high
         assign lane_byte = req.data_high[(i-8)*8 +: 8];
      end
      adl_lane #(.INDEX(i)) u_lane (
         .byte_in  (lane_byte),
         .count    (count_sat),
         .lane_out (lane_res[i])
      );
   end

   adl_merge #(.LANES(LANES)) u_merge (
      .lane_res   (lane_res),
      .byte_total (byte_total),
      .weighted   (weighted)
   );

   // The item in stage one moves on unless it carries a checksum and the
   // output register is occupied by one the receiver is not taking now.
   always_comb begin
      advance   = s1_valid_ff && (!s1_ff.last || !out_valid_ff || rsp.ready);
      req.ready = !s1_valid_ff || advance;
      accept    = req.valid && req.ready;

      s1_in.count      = count_sat;
      s1_in.byte_total = byte_total;
      s1_in.weighted   = weighted;
      s1_in.start_a    = mod_reduce({1'b0, req.start_value[SUM_W-1:0]});
      s1_in.start_b    = mod_reduce({1'b0, req.start_value[START_W-1:SUM_W]});
      s1_in.first      = req.first;
      s1_in.last       = req.last;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance && s1_ff.last) begin
         out_valid_in = 1'b1;
         out_data_in  = next_checksum;
      end else begin
         out_valid_in = out_valid_ff && !rsp.ready;
         out_data_in  = out_data_ff;
      end
   end

   adl_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .commit        (advance),
      .stage         (s1_ff),
      .next_checksum (next_checksum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.checksum = out_data_ff;

   `ASSERT_CLK(a_hold_on_full_output, clock, reset,
      (s1_valid_ff && s1_ff.last && out_valid_ff && !rsp.ready) |-> !req.ready,
      "last item would overwrite a waiting checksum")
   `ASSERT_CLK(a_result_from_last, clock, reset,
      $rose(out_valid_ff) |-> $past(advance && s1_ff.last),
      "checksum offered without a last item")
   `ASSERT_CLK(a_nonlast_flows, clock, reset,
      (s1_valid_ff && !s1_ff.last) |-> req.ready,
      "item without last flag stalled the input")

endmodule

`default_nettype wire
